FILE: design/mstep_pkg.sv
// Shared types and constants for the multi-motor full-step sequencer.
// Holds the channel payload structs, the command codes and the coil table.
// No dependencies.
package mstep_pkg;

	typedef enum logic [1:0] {
		CMD_TICK     = 2'd0,
		CMD_RUN      = 2'd1,
		CMD_STOP     = 2'd2,
		CMD_STOP_ALL = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [1:0]         motor_index;
		logic [7:0]         stage_delay;
		logic signed [7:0]  step_count;
	} mstep_in_t;

	typedef struct packed {
		logic [1:0] out_motor;
		logic [3:0] coil_pattern;
		logic       drive_valid;
		logic       running;
		logic       last;
	} mstep_out_t;

	// controller to datapath
	typedef struct packed {
		logic apply;
		logic step;
	} mstep_ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic last_motor;
	} mstep_stat_t;

	localparam logic [3:0] COIL_TABLE [4] = '{4'hA, 4'h6, 4'h5, 4'h9};

	// forward order walks the table up, reverse order walks it down
	function automatic logic [3:0] coil_lookup(input logic [1:0] stage, input logic fwd);
		logic [1:0] pos;
		pos = fwd ? stage : (2'd3 - stage);
		return COIL_TABLE[pos];
	endfunction

endpackage

FILE: design/multi_stepper_phase_sequencer_top.sv
// Top level of the multi-motor full-step sequencer.
// Instantiates mstep_ctrl and mstep_dp; depends on mstep_pkg.
//
//   channel   direction  payload       handshake
//   cmd       in         mstep_in_t    cmd_valid / cmd_stall
//   res       out        mstep_out_t   res_valid / res_stall
//
// Run, stop and stop-all are applied on acceptance. An accepted tick moves the
// controller to its walk state, which walks the motor entries one per cycle,
// unless the result side stalls, through a single shared update unit, with
// cmd_stall high for the whole walk; the next command is taken once the last
// motor has stepped. One result transfer per motor leaves the result register,
// loaded as that motor steps. Reset clears all motor state and drops any waiting result.
module multi_stepper_phase_sequencer_top #(
	parameter int NUM_MOTORS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  mstep_pkg::mstep_in_t  cmd_data,
	output logic                  res_valid,
	input  logic                  res_stall,
	output mstep_pkg::mstep_out_t res_data
);
	import mstep_pkg::*;

	mstep_ctrl_t ctrl;
	mstep_stat_t stat;

	mstep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_code  (cmd_data.cmd),
		.cmd_stall (cmd_stall),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	mstep_dp #(
		.NUM_MOTORS (NUM_MOTORS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_data  (cmd_data),
		.ctrl      (ctrl),
		.stat      (stat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

FILE: design/mstep_ctrl.sv
// Controller for the multi-motor sequencer: accepts commands and walks
// the motor entries once per tick. Depends on mstep_pkg.
module mstep_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  mstep_pkg::cmd_t       cmd_code,
	output logic                  cmd_stall,
	input  mstep_pkg::mstep_stat_t stat,
	output mstep_pkg::mstep_ctrl_t ctrl
);
	import mstep_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;

	always_comb begin
		state_d    = state_q;
		ctrl.apply = 1'b0;
		ctrl.step  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd_code == CMD_TICK) begin
						state_d = ST_WALK;
					end else begin
						ctrl.apply = 1'b1;
					end
				end
			end
			ST_WALK: begin
				// advance one motor whenever the result register can take it
				ctrl.step = stat.out_free;
				if (stat.out_free && stat.last_motor) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	a_walk_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> !ctrl.apply)
		else $error("command applied during tick walk");
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state not one-hot");
	a_step_only_walking: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.step |-> (state_q == ST_WALK))
		else $error("motor stepped outside tick walk");
`endif

endmodule

FILE: design/mstep_dp.sv
// Datapath for the multi-motor sequencer: per-motor delay, timer, count and
// stage registers, the per-motor update and the result register.
// Depends on mstep_pkg.
module mstep_dp #(
	parameter int NUM_MOTORS = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mstep_pkg::mstep_in_t   cmd_data,
	input  mstep_pkg::mstep_ctrl_t ctrl,
	output mstep_pkg::mstep_stat_t stat,
	output logic                   res_valid,
	input  logic                   res_stall,
	output mstep_pkg::mstep_out_t  res_data
);
	import mstep_pkg::*;

	localparam int MW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
	localparam logic [MW-1:0] LAST_M = MW'(NUM_MOTORS - 1);

	logic [7:0]        delay_q [NUM_MOTORS];
	logic [7:0]        timer_q [NUM_MOTORS];
	logic signed [7:0] steps_q [NUM_MOTORS];
	logic [1:0]        stage_q [NUM_MOTORS];

	logic [MW-1:0] mot_q;
	mstep_out_t    res_q;
	logic          res_valid_q;

	logic [MW+1:0] idx_w;
	logic [MW+1:0] mot_w;
	logic          idx_ok;

	logic [7:0]        t_cur, t_dec, t_nxt;
	logic signed [7:0] s_cur, s_nxt;
	logic [1:0]        st_cur, st_nxt;
	logic              due, fwd;
	logic [3:0]        pat;

	assign idx_w  = {{MW{1'b0}}, cmd_data.motor_index};
	assign mot_w  = {2'b00, mot_q};
	assign idx_ok = (32'(cmd_data.motor_index) < NUM_MOTORS);

	// per-motor tick update: count down, then emit if due
	always_comb begin
		t_cur  = timer_q[mot_q];
		s_cur  = steps_q[mot_q];
		st_cur = stage_q[mot_q];
		fwd    = !s_cur[7];
		t_dec  = (s_cur != 8'sd0 && t_cur != 8'd0) ? (t_cur - 8'd1) : t_cur;
		due    = (t_dec == 8'd0) && (s_cur != 8'sd0);
		pat    = due ? coil_lookup(st_cur, fwd) : 4'd0;
		st_nxt = due ? (st_cur + 2'd1) : st_cur;
		s_nxt  = s_cur;
		if (due && st_cur == 2'd3) begin
			s_nxt = fwd ? (s_cur - 8'sd1) : (s_cur + 8'sd1);
		end
		t_nxt = (due && s_nxt != 8'sd0) ? delay_q[mot_q] : t_dec;
	end

	assign stat.last_motor = (mot_q == LAST_M);
	assign stat.out_free   = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < NUM_MOTORS; m++) begin
				delay_q[m] <= 8'd0;
				timer_q[m] <= 8'd0;
				steps_q[m] <= 8'sd0;
				stage_q[m] <= 2'd0;
			end
			mot_q <= '0;
		end else if (ctrl.apply) begin
			if (cmd_data.cmd == CMD_STOP_ALL) begin
				for (int m = 0; m < NUM_MOTORS; m++) begin
					delay_q[m] <= 8'd0;
					timer_q[m] <= 8'd0;
					steps_q[m] <= 8'sd0;
					stage_q[m] <= 2'd0;
				end
			end else if (idx_ok) begin
				// run with a zero count behaves as stop
				timer_q[idx_w[MW-1:0]] <= 8'd0;
				stage_q[idx_w[MW-1:0]] <= 2'd0;
				if (cmd_data.cmd == CMD_RUN && cmd_data.step_count != 8'sd0) begin
					delay_q[idx_w[MW-1:0]] <= cmd_data.stage_delay;
					steps_q[idx_w[MW-1:0]] <= cmd_data.step_count;
				end else begin
					delay_q[idx_w[MW-1:0]] <= 8'd0;
					steps_q[idx_w[MW-1:0]] <= 8'sd0;
				end
			end
		end else if (ctrl.step) begin
			timer_q[mot_q] <= t_nxt;
			steps_q[mot_q] <= s_nxt;
			stage_q[mot_q] <= st_nxt;
			mot_q <= stat.last_motor ? '0 : (mot_q + MW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctrl.step) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			res_q.out_motor    <= mot_w[1:0];
			res_q.coil_pattern <= pat;
			res_q.drive_valid  <= due;
			res_q.running      <= (s_nxt != 8'sd0);
			res_q.last         <= stat.last_motor;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

`ifndef ASSERT_OFF
	a_step_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.step |=> res_valid)
		else $error("stepped motor produced no result");
	a_idle_coils_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_data.drive_valid) |-> (res_data.coil_pattern == 4'd0))
		else $error("coil pattern without drive");
	a_drive_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.drive_valid) |-> (res_data.coil_pattern != 4'd0))
		else $error("drive with empty coil pattern");
	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.step && stat.last_motor) |=> (mot_q == '0) && res_data.last)
		else $error("motor walk did not wrap after the last motor");
`endif

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for multi_stepper_phase_sequencer_top: a directed table, then random
// commands, checked against an in-bench predictor of the coil sequence. Depends on mstep_pkg.
`timescale 1ns / 100ps

module tb_top;
	import mstep_pkg::*;

	localparam int NUM_MOTORS  = 4;
	localparam int N_RANDOM    = 405;
	localparam int HOLD_AT     = 150;
	localparam int HOLD_ITEMS  = 60;
	localparam int DRAIN_AT    = 280;
	localparam int QUIET_ITEMS = 40;
	localparam int LONG_HOLD   = 150;
	localparam int SETTLE      = 24;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_SHOWN   = 10;

	localparam logic [3:0] PHASE_COILS [4] = '{4'hA, 4'h6, 4'h5, 4'h9};

	// one command plus, where pinned, the tick results written out per motor (motor 0 lowest)
	typedef struct packed {
		mstep_in_t   item;
		logic        pinned;
		logic [15:0] pats;
		logic [3:0]  drives;
		logic [3:0]  runs;
	} step_row_t;

	localparam step_row_t DIRECTED [25] = '{
		'{'{CMD_TICK,     2'd0, 8'h00, 8'sh00}, 1'b1, 16'h0000, 4'b0000, 4'b0000},
		'{'{CMD_RUN,      2'd0, 8'h00, 8'sh01}, 1'b0, 16'h0000, 4'b0000, 4'b0000},
		'{'{CMD_TICK,     2'd3, 8'hFF, 8'sh7F}, 1'b1, 16'h000A, 4'b0001, 4'b0001},
		'{'{CMD_TICK,     2'd0, 8'h00, 8'sh00}, 1'b1, 16'h0006, 4'b0001, 4'b0001},
		'{'{CMD_TICK,     2'd1, 8'h5A, 8'sh80}, 1'b1, 16'h0005, 4'b0001, 4'b0001},
		'{'{CMD_TICK,     2'd0, 8'h00, 8'sh00}, 1'b1, 16'h0009, 4'b0001, 4'b0000},
		'{'{CMD_TICK,     2'd2, 8'hA5, 8'sh3C}, 1'b1, 16'h0000, 4'b0000, 4'b0000},
		'{'{CMD_RUN,      2'd3, 8'hFF, 8'sh80}, 1'b0, 16'h0000, 4'b0000, 4'b0000},
		'{'{CMD_RUN,      2'd1, 8'h01, 8'sh7F}, 1'b0, 16'h0000, 4'b0000, 4'b0000},
		'{'{CMD_RUN,      2'd2, 8'h02, 8'sh00}, 1'b0, 16'h0000, 4'b0000, 4'b0000},
		'{'{CMD_TICK,     2'd0, 8'h00, 8'sh00}, 1'b1, 16'h90A0, 4'b1010, 4'b1010},
		'{'{CMD_TICK,     2'd0, 8'h00, 8'sh00}, 1'b0, 16'h0000, 4'b0000, 4'b0000},
		'{'{CMD_TICK,     2'd1, 8'h33, 8'sh11}, 1'b0, 16'h0000, 4'b0000, 4'b0000},
		'{'{CMD_TICK,     2'd0, 8'h00, 8'sh00}, 1'b0, 16'h0000, 4'b0000, 4'b0000},
		'{'{CMD_STOP,     2'd1, 8'h55, 8'sh2A}, 1'b0, 16'h0000, 4'b0000, 4'b0000},
		'{'{CMD_TICK,     2'd0, 8'h00, 8'sh00}, 1'b0, 16'h0000, 4'b0000, 4'b0000},
		'{'{CMD_RUN,      2'd0, 8'h00, 8'shFF}, 1'b0, 16'h0000, 4'b0000, 4'b0000},
		'{'{CMD_TICK,     2'd0, 8'h00, 8'sh00}, 1'b1, 16'h0009, 4'b0001, 4'b1001},
		'{'{CMD_TICK,     2'd0, 8'h00, 8'sh00}, 1'b0, 16'h0000, 4'b0000, 4'b0000},
		'{'{CMD_TICK,     2'd0, 8'h00, 8'sh00}, 1'b0, 16'h0000, 4'b0000, 4'b0000},
		'{'{CMD_TICK,     2'd0, 8'h00, 8'sh00}, 1'b0, 16'h0000, 4'b0000, 4'b0000},
		'{'{CMD_STOP_ALL, 2'd2, 8'hFF, 8'sh7F}, 1'b0, 16'h0000, 4'b0000, 4'b0000},
		'{'{CMD_TICK,     2'd0, 8'h00, 8'sh00}, 1'b1, 16'h0000, 4'b0000, 4'b0000},
		'{'{CMD_RUN,      2'd2, 8'h03, 8'sh05}, 1'b0, 16'h0000, 4'b0000, 4'b0000},
		'{'{CMD_TICK,     2'd0, 8'h00, 8'sh00}, 1'b0, 16'h0000, 4'b0000, 4'b0000}
	};

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	mstep_in_t  cmd_data  = '0;
	step_row_t  cmd_tag   = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	mstep_out_t res_data;

	logic [7:0] delay_of [NUM_MOTORS] = '{default: '0};
	logic [7:0] timer_of [NUM_MOTORS] = '{default: '0};
	logic [7:0] steps_of [NUM_MOTORS] = '{default: '0};
	logic [1:0] stage_of [NUM_MOTORS] = '{default: '0};

	mstep_out_t coil_q [$];
	int         mismatches  = 0;
	int         idle_cycles = 0;
	bit         hold_req    = 1'b0;
	bit         quiet       = 1'b0;

	multi_stepper_phase_sequencer_top #(.NUM_MOTORS(NUM_MOTORS)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void park_motor(input int m);
		delay_of[m] = '0;
		timer_of[m] = '0;
		steps_of[m] = '0;
		stage_of[m] = '0;
	endfunction

	// advance the motor state for one command; a tick queues one drive result per motor
	function automatic void sequence_motors(input mstep_in_t c, input step_row_t tag);
		mstep_out_t r;
		logic       fwd;
		int         m;
		case (c.cmd)
			CMD_RUN, CMD_STOP: begin
				park_motor(int'(c.motor_index));
				if (c.cmd == CMD_RUN && c.step_count != 0) begin
					delay_of[c.motor_index] = c.stage_delay;
					steps_of[c.motor_index] = c.step_count;
				end
			end
			CMD_STOP_ALL: begin
				for (m = 0; m < NUM_MOTORS; m++)
					park_motor(m);
			end
			default: begin
				for (m = 0; m < NUM_MOTORS; m++)
					if (steps_of[m] != 0 && timer_of[m] != 0)
						timer_of[m] = timer_of[m] - 8'd1;
				for (m = 0; m < NUM_MOTORS; m++) begin
					r = '0;
					r.out_motor = 2'(m);
					if (timer_of[m] == 0 && steps_of[m] != 0) begin
						fwd = !steps_of[m][7];
						r.coil_pattern = fwd ? PHASE_COILS[stage_of[m]]
							: PHASE_COILS[2'd3 - stage_of[m]];
						r.drive_valid = 1'b1;
						// a full cycle ends on the last stage: count moves toward zero
						if (stage_of[m] == 2'd3)
							steps_of[m] = fwd ? steps_of[m] - 8'd1 : steps_of[m] + 8'd1;
						stage_of[m] = stage_of[m] + 2'd1;
						if (steps_of[m] != 0)
							timer_of[m] = delay_of[m];
					end
					r.running = steps_of[m] != 0;
					r.last = (m == NUM_MOTORS - 1);
					if (tag.pinned) begin
						r.coil_pattern = tag.pats[4*m +: 4];
						r.drive_valid = tag.drives[m];
						r.running = tag.runs[m];
					end
					coil_q.push_back(r);
				end
			end
		endcase
	endfunction

	task automatic report(input string what, input mstep_out_t want, input mstep_out_t got);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("mismatch (%s) at %0t: motor %0d/%0d coils %h/%h drive %b/%b %s %b/%b %s %b/%b",
				what, $realtime, want.out_motor, got.out_motor, want.coil_pattern,
				got.coil_pattern, want.drive_valid, got.drive_valid, "running",
				want.running, got.running, "last", want.last, got.last);
	endtask

	always @(posedge clk) begin : check_drive
		mstep_out_t want;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				sequence_motors(cmd_data, cmd_tag);
			if (res_valid && !res_stall) begin
				if (coil_q.size() == 0) begin
					report("unexpected", '0, res_data);
				end else begin
					want = coil_q.pop_front();
					if (res_data.out_motor !== want.out_motor
						|| res_data.coil_pattern !== want.coil_pattern
						|| res_data.drive_valid !== want.drive_valid
						|| res_data.running !== want.running
						|| res_data.last !== want.last)
						report("expected/actual", want, res_data);
				end
			end
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin : watchdog
		wait (idle_cycles >= STALL_LIMIT);
		$display("tb_top: FAIL");
		$finish;
	end

	// result side: short random stalls, one long hold-off on request, none at the end
	initial begin : res_side
		bit held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				res_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				res_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	function automatic step_row_t random_row();
		step_row_t row;
		int        sel;
		row = '0;
		sel = $urandom_range(0, 99);
		row.item.motor_index = 2'($urandom);
		row.item.stage_delay = 8'($urandom);
		row.item.step_count  = 8'($urandom);
		if (sel < 62) begin
			row.item.cmd = CMD_TICK;
		end else if (sel < 88) begin
			row.item.cmd = CMD_RUN;
			// mostly short runs with short delays, so motors finish and restart often
			if ($urandom_range(0, 9) < 7) begin
				row.item.stage_delay = 8'($urandom_range(0, 3));
				row.item.step_count = 8'($urandom_range(1, 3));
				if ($urandom_range(0, 1) == 1)
					row.item.step_count = -row.item.step_count;
			end else if ($urandom_range(0, 2) == 0) begin
				row.item.step_count = '0;
			end
		end else if (sel < 97) begin
			row.item.cmd = CMD_STOP;
		end else begin
			row.item.cmd = CMD_STOP_ALL;
		end
		return row;
	endfunction

	// hold the transfer until accepted; valid stays high for the caller to drop or reuse
	task automatic offer(input step_row_t row);
		cmd_valid <= 1'b1;
		cmd_data  <= row.item;
		cmd_tag   <= row;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	task automatic maybe_rest();
		if (!quiet && $urandom_range(0, 4) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	initial begin : stimulus
		int i;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[k]) begin
			offer(DIRECTED[k]);
			maybe_rest();
		end
		for (i = 0; i < N_RANDOM; i++) begin
			if (i == HOLD_AT)
				hold_req = 1'b1;
			if (i >= N_RANDOM - QUIET_ITEMS)
				quiet = 1'b1;
			if (i == DRAIN_AT) begin
				cmd_valid <= 1'b0;
				do @(posedge clk); while (coil_q.size() != 0);
			end
			offer(random_row());
			// keep offering back to back while the result side is held off
			if (i < HOLD_AT || i >= HOLD_AT + HOLD_ITEMS)
				maybe_rest();
		end
		cmd_valid <= 1'b0;
		do @(posedge clk); while (coil_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && coil_q.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

FILE: files.f
design/mstep_pkg.sv
design/mstep_ctrl.sv
design/mstep_dp.sv
design/multi_stepper_phase_sequencer_top.sv
dv/tb_top.sv
